// ----- design/msb_pkg.sv -----
// Shared types and constants for the masked sprite blitter.
`default_nettype none
package msb_pkg;

  localparam int FRAME_WIDTH_DEF  = 320;
  localparam int FRAME_HEIGHT_DEF = 240;
  localparam int COLL_X_MAX       = 319;
  localparam int COLL_Y_MAX       = 199;
  localparam logic [5:0] VOFS_RESET = 6'd20;
  localparam logic [7:0] COLL_OOR   = 8'hFF;
  localparam logic [1:0] MASK_OPAQUE = 2'b11;

  typedef enum logic [1:0] {
    OP_SPRITE = 2'd0,
    OP_FONT   = 2'd1,
    OP_COLL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } bk_state_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    op_t               op;
    logic signed [9:0] x;
    logic              row_ok;
    logic [9:0]        row_idx;
    logic [7:0]        pix;
    logic [7:0]        msk;
    logic [3:0]        col;
    logic              coll_oor;
  } item_t;

endpackage
`default_nettype wire

// ----- design/msb_front.sv -----
// Front end: holds the vertical offset and classifies incoming items.
`default_nettype none
module msb_front #(
  parameter int FRAME_HEIGHT = msb_pkg::FRAME_HEIGHT_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [5:0]          cfg_wdata,
  input  wire [1:0]          in_operation,
  input  wire signed [9:0]   in_x_pos,
  input  wire signed [8:0]   in_y_pos,
  input  wire [7:0]          in_pixel_byte,
  input  wire [7:0]          in_mask_byte,
  input  wire [3:0]          in_fore_color,
  output msb_pkg::item_t     item
);
  import msb_pkg::*;

  logic [5:0]         vofs_r;
  logic [5:0]         vofs_nxt;
  logic signed [10:0] row;

  assign vofs_nxt = cfg_we ? cfg_wdata : vofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vofs_r <= VOFS_RESET;
    end else begin
      vofs_r <= vofs_nxt;
    end
  end

  assign row = 11'(in_y_pos) + $signed({5'd0, vofs_r});

  always_comb begin
    item.op       = op_t'(in_operation);
    item.x        = in_x_pos;
    item.row_ok   = (row >= 0) && (int'(row) < FRAME_HEIGHT);
    item.row_idx  = row[9:0];
    item.pix      = in_pixel_byte;
    item.msk      = in_mask_byte;
    item.col      = in_fore_color;
    item.coll_oor = (in_x_pos < 0) || (int'(in_x_pos) > COLL_X_MAX) ||
                    (in_y_pos < 0) || (int'(in_y_pos) > COLL_Y_MAX);
  end

endmodule
`default_nettype wire

// ----- design/msb_queue.sv -----
// Two-entry queue between the front and back ends.
`default_nettype none
module msb_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  msb_pkg::item_t  push_item,
  output logic            full,
  input  wire             pop,
  output logic            head_valid,
  output msb_pkg::item_t  head_item
);
  import msb_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic       wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- design/msb_back.sv -----
// Back end: framebuffer memory, clear sweep and per-byte read-modify-write.
`default_nettype none
module msb_back #(
  parameter int FRAME_WIDTH  = msb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = msb_pkg::FRAME_HEIGHT_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  input  msb_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [7:0]      out_pixels_read
);
  import msb_pkg::*;

  localparam int ROW_BYTES = (FRAME_WIDTH + 1) / 2;
  localparam int STORE     = ROW_BYTES * FRAME_HEIGHT;
  localparam int AW        = $clog2(STORE);

  logic [7:0]    mem [STORE];
  logic [7:0]    rdata_r;

  bk_state_t     state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    j_r, j_nxt;
  logic [7:0]    res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_px_r, out_px_nxt;

  logic              last_j;
  logic signed [10:0] cbyte;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        merged;
  logic              any_valid;
  logic              out_free;
  logic              vld [2];
  logic [1:0]        kk [2];

  assign last_j   = (j_r == 2'd2) || ((j_r == 2'd1) && !q_item.x[0]);
  assign cbyte    = 11'(q_item.x >>> 1) + $signed({9'd0, j_r});
  assign addr     = AW'(32'(q_item.row_idx) * ROW_BYTES + 32'(cbyte[9:0]));
  assign out_free = !out_valid_r || out_ready;

  // Per-nibble merge; nibble h of byte j holds pixel k = 2j + h - x[0].
  always_comb begin
    logic signed [3:0] k;
    logic [1:0] s, m;
    logic [3:0] old, nw;
    merged    = rdata_r;
    res_nxt   = res_r;
    any_valid = 1'b0;
    for (int h = 0; h < 2; h++) begin
      k = $signed({1'b0, j_r, 1'b0}) + 4'(h) - $signed({3'd0, q_item.x[0]});
      vld[h] = q_item.row_ok && (k >= 0) && (k <= 3) && (cbyte >= 0) &&
               (2 * int'(cbyte) + h < FRAME_WIDTH);
      kk[h] = k[1:0];
      s   = q_item.pix[(3 - kk[h]) * 2 +: 2];
      m   = q_item.msk[(3 - kk[h]) * 2 +: 2];
      old = rdata_r[h * 4 +: 4];
      case (q_item.op)
        OP_SPRITE: begin
          if (m != MASK_OPAQUE) nw = (old & {2'b00, m}) | {2'b00, s};
          else if (s != 2'b00)  nw = {2'b00, s};
          else                  nw = old;
        end
        OP_FONT: nw = (s != 2'b00) ? q_item.col : 4'd0;
        default: nw = old;
      endcase
      if (vld[h]) begin
        merged[h * 4 +: 4] = nw;
        any_valid = 1'b1;
        res_nxt[(3 - kk[h]) * 2 +: 2] = old[1:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (int'(clr_r) == STORE - 1) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (!last_j) state_nxt = ST_READ;
        else if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs and datapath registers
  always_comb begin
    clr_nxt       = clr_r;
    j_nxt         = j_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wr_addr       = addr;
    wr_data       = merged;
    rd_addr       = addr;
    out_valid_nxt = out_valid_r && !out_ready;
    out_px_nxt    = out_px_r;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_r;
        wr_data = 8'd0;
        rd_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: j_nxt = 2'd0;
      ST_READ: ;
      ST_WRITE: begin
        we = any_valid && ((q_item.op == OP_SPRITE) || (q_item.op == OP_FONT));
        if (!last_j) begin
          j_nxt = j_r + 2'd1;
        end else if (out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          if (q_item.op != OP_COLL) out_px_nxt = 8'd0;
          else if (q_item.coll_oor) out_px_nxt = COLL_OOR;
          else out_px_nxt = res_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      j_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_px_r <= out_px_nxt;
    if (state_r == ST_IDLE) res_r <= 8'd0;
    else if (state_r == ST_WRITE) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_pixels_read = out_px_r;

  a_pop_in_write: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_WRITE) && last_j && q_valid)
    else $error("pop outside final write step");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (state_r == ST_CLEAR) && !out_valid_r)
    else $error("reset did not start clear sweep");
  a_no_coll_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> !(we && (q_item.op == OP_COLL)))
    else $error("collision read wrote memory");
  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("result lost after pop");

endmodule
`default_nettype wire

// ----- design/masked_sprite_blitter.sv -----
// Top level of the masked sprite blitter.
// Input channel in_* (valid/ready) carries one 2bpp source byte with a
// position and an operation: masked sprite draw, font draw, collision
// read or none. Every item yields exactly one transfer on out_* (valid/ready):
// the collision byte for a read (FFh out of range), 0 otherwise.
// The front end classifies items into a two-entry queue; the back end
// performs a read-modify-write on each framebuffer byte the four pixels
// touch (two at an even x, three at an odd x), one read and one write
// per byte on the single memory port; only a draw writes the byte back.
// It finishes each item before it takes the next, passing through its
// idle state between items.
// After reset the block sweeps the framebuffer to zero, one byte a cycle,
// ((FRAME_WIDTH+1)/2)*FRAME_HEIGHT bytes (38400 at the defaults);
// items queue up to two deep meanwhile. cfg_we writes vertical_offset
// (reset 20) and is meant to be used while idle.
// When the receiver stalls the result holds in the output register; the
// back end finishes its next item then waits, and the queue fills before
// in_ready drops.
`default_nettype none
module masked_sprite_blitter #(
  parameter int FRAME_WIDTH  = msb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = msb_pkg::FRAME_HEIGHT_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire [5:0]        cfg_wdata,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [1:0]        in_operation,
  input  wire signed [9:0] in_x_pos,
  input  wire signed [8:0] in_y_pos,
  input  wire [7:0]        in_pixel_byte,
  input  wire [7:0]        in_mask_byte,
  input  wire [3:0]        in_fore_color,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [7:0]       out_pixels_read
);
  import msb_pkg::*;

  item_t fr_item, hd_item;
  logic  q_full, q_valid, q_pop;

  assign in_ready = !q_full;

  msb_front #(.FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_operation, .in_x_pos, .in_y_pos, .in_pixel_byte, .in_mask_byte,
    .in_fore_color, .item(fr_item)
  );

  msb_queue u_queue (
    .clk, .rst_n,
    .push(in_valid && in_ready), .push_item(fr_item), .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_item(hd_item)
  );

  msb_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
    .clk, .rst_n, .q_valid, .q_item(hd_item), .q_pop,
    .out_valid, .out_ready, .out_pixels_read
  );

endmodule
`default_nettype wire
